// File: design/abs_pkg.sv
// Shared types, codes and checksum function for the alternating-bit sender.
`default_nettype none

package abs_pkg;

	localparam int PayloadBytes = 20;

	// Event codes carried in the cmd field; the fourth code means nothing
	typedef enum logic [1:0] {
		CMD_MSG     = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2
	} cmd_t;

	// 20-byte message, byte i at bits 8i
	typedef struct packed {
		logic [31:0] hi;
		logic [63:0] mid;
		logic [63:0] lo;
	} msg_t;

	// One input transaction
	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        payload_lo;
		logic [63:0]        payload_mid;
		logic [31:0]        payload_hi;
		logic signed [31:0] in_seq;
		logic signed [31:0] in_ack;
		logic signed [31:0] in_checksum;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic               send_valid;
		logic               out_seq;
		logic               out_ack;
		logic signed [31:0] out_checksum;
		logic [63:0]        out_payload_lo;
		logic [63:0]        out_payload_mid;
		logic [31:0]        out_payload_hi;
		logic               timer_start;
		logic               timer_stop;
		logic               dropped;
	} result_t;

	// Pending-message queue status
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	// Wrapping sum of the 20 payload bytes, each sign-extended
	function automatic logic [31:0] byte_sum(msg_t m);
		logic [8*PayloadBytes-1:0] flat;
		logic [31:0]               acc;
		flat = m;
		acc  = '0;
		for (int i = 0; i < PayloadBytes; i++) begin
			acc = acc + {{24{flat[8*i+7]}}, flat[8*i +: 8]};
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

// File: design/abs_chan_if.sv
// Valid/ready channel interface carrying one payload struct per transaction.
`default_nettype none

interface abs_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/abs_fifo.sv
// Pending-message FIFO: memory plus a registered head word that is always current.
`default_nettype none

module abs_fifo #(
	parameter int Depth = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  wire abs_pkg::msg_t      push_data,
	input  wire                     pop,
	output abs_pkg::msg_t           head,
	output abs_pkg::fifo_stat_t     stat
);
	import abs_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, rd_next;
	logic [CntW-1:0] cnt_q;
	msg_t            mem_q [Depth];
	msg_t            head_q;

	function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	// Address that will be the head after this edge
	assign rd_next = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;

	// Memory write and registered head read; a push into an empty queue bypasses
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (push && (wr_ptr_q == rd_next)) begin
			head_q <= push_data;
		end else begin
			head_q <= mem_q[rd_next];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			rd_ptr_q <= rd_next;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head       = head_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CntW'(Depth));

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

`default_nettype wire

// File: design/alternating_bit_sender.sv
// Alternating-bit protocol sender: event decode, held packet, queue and result register.
//
//  channel | dir | payload            | transaction
//  item    | in  | abs_pkg::item_t    | one event (message, ack packet, timer expiry)
//  result  | out | abs_pkg::result_t  | exactly one result per event
//
// An accepted item passes the input register, then the result register; one item per cycle while result is not stalled.
// The single decision stage (checksum adder trees, queue head compare) sets the cycle.
// The queue head is read from a registered memory port that is refreshed every cycle.
// Reset sets the sequence bit to 1 and clears the awaiting flag and the queue pointers.
// A stall on result holds the result register; item stays ready while stage 1 is free.
`default_nettype none

module alternating_bit_sender #(
	parameter int BUFFER_MESSAGES = 64
) (
	input wire         clk,
	input wire         arst_n,
	abs_chan_if.sink   item,
	abs_chan_if.source result
);
	import abs_pkg::*;

	// Stage 1 input register
	item_t item_s1;
	logic  valid_s1;

	// Result register
	result_t res_q;
	logic    out_valid_q;

	// Protocol state
	logic        last_seq_q;
	logic        awaiting_q;
	logic [31:0] held_chk_q;
	msg_t        held_q;

	// Queue
	msg_t       fifo_head;
	fifo_stat_t fifo_stat;
	logic       push, pop;

	logic out_free, adv;

	// Decision signals
	msg_t        msg_in, new_src;
	logic        seq_new;
	logic [31:0] new_chk, ack_sum;
	logic        ack_ok, do_new, do_push, do_pop, clr_await;
	result_t     res_d;

	assign out_free   = !out_valid_q || result.ready;
	assign adv        = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.payload;
		end
	end

	// Checksums for the arriving ack and for a newly sent packet
	assign msg_in  = '{hi: item_s1.payload_hi, mid: item_s1.payload_mid,
		lo: item_s1.payload_lo};
	assign seq_new = ~last_seq_q;
	assign ack_sum = 32'(item_s1.in_seq) + 32'(item_s1.in_ack) + byte_sum(msg_in);
	assign ack_ok  = awaiting_q && (ack_sum == 32'(item_s1.in_checksum))
		&& (32'(item_s1.in_ack) == {31'b0, last_seq_q});
	assign new_src = (item_s1.cmd == CMD_ACK) ? fifo_head : msg_in;
	assign new_chk = {31'b0, seq_new} + byte_sum(new_src);

	// Event decode and result
	always_comb begin
		res_d     = '0;
		do_new    = 1'b0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		clr_await = 1'b0;
		unique case (item_s1.cmd)
			CMD_MSG: begin
				if (!awaiting_q) begin
					do_new = 1'b1;
				end else if (fifo_stat.full) begin
					res_d.dropped = 1'b1;
				end else begin
					do_push = 1'b1;
				end
			end
			CMD_ACK: begin
				if (ack_ok) begin
					res_d.timer_stop = 1'b1;
					if (fifo_stat.empty) begin
						clr_await = 1'b1;
					end else begin
						do_pop = 1'b1;
						do_new = 1'b1;
					end
				end
			end
			CMD_TIMEOUT: begin
				if (awaiting_q) begin
					res_d.send_valid      = 1'b1;
					res_d.out_seq         = last_seq_q;
					res_d.out_checksum    = held_chk_q;
					res_d.out_payload_lo  = held_q.lo;
					res_d.out_payload_mid = held_q.mid;
					res_d.out_payload_hi  = held_q.hi;
					res_d.timer_start     = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (do_new) begin
			res_d.send_valid      = 1'b1;
			res_d.out_seq         = seq_new;
			res_d.out_checksum    = new_chk;
			res_d.out_payload_lo  = new_src.lo;
			res_d.out_payload_mid = new_src.mid;
			res_d.out_payload_hi  = new_src.hi;
			res_d.timer_start     = 1'b1;
		end
	end

	assign push = adv && do_push;
	assign pop  = adv && do_pop;

	// Protocol control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q <= 1'b1;
			awaiting_q <= 1'b0;
		end else if (adv) begin
			if (do_new) begin
				last_seq_q <= seq_new;
				awaiting_q <= 1'b1;
			end else if (clr_await) begin
				awaiting_q <= 1'b0;
			end
		end
	end

	// Held packet for retransmission
	always_ff @(posedge clk) begin
		if (adv && do_new) begin
			held_q     <= new_src;
			held_chk_q <= new_chk;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = res_q;

	abs_fifo #(
		.Depth(BUFFER_MESSAGES)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (msg_in),
		.pop       (pop),
		.head      (fifo_head),
		.stat      (fifo_stat)
	);

	a_queue_needs_await: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_stat.empty |-> awaiting_q) else $error("messages queued while idle");
	a_send_starts_timer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.send_valid |-> res_q.timer_start)
		else $error("packet sent without timer start");
	a_new_flips_seq: assert property (@(posedge clk) disable iff (!arst_n)
		adv && do_new |=> awaiting_q && (last_seq_q != $past(last_seq_q)))
		else $error("new packet did not flip sequence bit");

endmodule

`default_nettype wire
